// File: rtl/core/hmppk_pkg.sv
package hmppk_pkg;

    localparam logic [63:0] GOLDEN_MULT = 64'h9E3779B97F4A7C15;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISS     = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic       OP_LOOKUP   = 1'b0;
    localparam logic       OP_INSERT   = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH0,
        S_HASH1,
        S_HASH2,
        S_HEAD,
        S_INSERT,
        S_READ,
        S_CHECK,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic hash0;
        logic hash1;
        logic hash2;
        logic head_rd;
        logic insert;
        logic entry_rd;
        logic follow;
        logic clear_step;
        logic set_full;
        logic set_miss;
        logic set_hit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic is_insert;
        logic pool_full;
        logic cur_empty;
        logic match;
    } t_status;

endpackage

// File: rtl/core/hmppk_datapath.sv
module hmppk_datapath #(
    parameter int HASH_BITS    = 8,
    parameter int POOL_ENTRIES = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hmppk_pkg::t_cmd     i_cmd,
    input  logic                i_operation,
    input  logic [63:0]         i_key_address,
    input  logic [31:0]         i_key_tag,
    input  logic [31:0]         i_new_value,
    output hmppk_pkg::t_status  o_status_flags,
    output logic [1:0]          o_status,
    output logic [31:0]         o_found_value
);

    localparam int BUCKETS = 1 << HASH_BITS;
    localparam int PW      = $clog2(POOL_ENTRIES + 1);
    localparam int IW      = $clog2(POOL_ENTRIES);
    localparam logic [PW-1:0] NO_ENTRY = PW'(POOL_ENTRIES);

    // bucket heads and pool memories
    logic [PW-1:0] r_head_mem [BUCKETS];
    logic [PW-1:0] r_next_mem [POOL_ENTRIES];
    logic [63:0]   r_addr_mem [POOL_ENTRIES];
    logic [31:0]   r_tag_mem  [POOL_ENTRIES];
    logic [31:0]   r_val_mem  [POOL_ENTRIES];

    logic                 r_op;
    logic [63:0]          r_addr;
    logic [31:0]          r_tag;
    logic [31:0]          r_val;
    logic [31:0]          r_pp0, r_pp1, r_pp2;
    logic [HASH_BITS-1:0] r_bucket;
    logic [HASH_BITS-1:0] r_clr_idx;
    logic                 r_clr_done;
    logic [PW-1:0]        r_used;
    logic [PW-1:0]        r_cur;
    logic [PW-1:0]        r_rd_next;
    logic [63:0]          r_rd_addr;
    logic [31:0]          r_rd_tag;
    logic [31:0]          r_rd_val;
    logic [1:0]           r_status;
    logic [31:0]          r_found;
    logic [63:0]          w_prod;

    // bits 63:32 of the low 64 bits of the product, from three 32x32 partial products over cycles
    assign w_prod = {r_pp0, 32'd0} + {r_pp1, 32'd0} + {r_pp2[31:0], 32'd0};

    // clearing pass counter, restarts at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx  <= '0;
            r_clr_done <= 1'b0;
        end else if (i_cmd.clear_step) begin
            r_clr_idx  <= r_clr_idx + 1'b1;
            r_clr_done <= (r_clr_idx == HASH_BITS'(BUCKETS - 1));
        end else if (i_cmd.load) begin
            r_clr_idx  <= '0;
            r_clr_done <= 1'b0;
        end
    end

    // key capture, hashing, reset sweep, chain walk, insert and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_operation;
            r_addr <= i_key_address;
            r_tag  <= i_key_tag;
            r_val  <= i_new_value;
        end
        // lo*lo high half, then cross terms low halves
        if (i_cmd.hash0) begin
            r_pp0 <= 32'((64'(r_addr[31:0]) * 64'(hmppk_pkg::GOLDEN_MULT[31:0])) >> 32);
            r_pp1 <= 32'(64'(r_addr[31:0]) * 64'(hmppk_pkg::GOLDEN_MULT[63:32]));
        end
        if (i_cmd.hash1) begin
            r_pp2 <= 32'(64'(r_addr[63:32]) * 64'(hmppk_pkg::GOLDEN_MULT[31:0]));
        end
        if (i_cmd.hash2) begin
            r_bucket <= w_prod[63 -: HASH_BITS];
        end
        if (i_cmd.clear_step) begin
            r_head_mem[r_clr_idx] <= NO_ENTRY;
        end
        if (i_cmd.head_rd) begin
            r_cur <= r_head_mem[r_bucket];
        end
        if (i_cmd.insert) begin
            r_next_mem[r_used[IW-1:0]] <= r_cur;
            r_addr_mem[r_used[IW-1:0]] <= r_addr;
            r_tag_mem[r_used[IW-1:0]]  <= r_tag;
            r_val_mem[r_used[IW-1:0]]  <= r_val;
            r_head_mem[r_bucket]       <= r_used;
            r_used                     <= r_used + 1'b1;
        end else if (i_cmd.clear_step) begin
            r_used <= '0;
        end
        if (i_cmd.entry_rd) begin
            r_rd_next <= r_next_mem[r_cur[IW-1:0]];
            r_rd_addr <= r_addr_mem[r_cur[IW-1:0]];
            r_rd_tag  <= r_tag_mem[r_cur[IW-1:0]];
            r_rd_val  <= r_val_mem[r_cur[IW-1:0]];
        end
        if (i_cmd.follow) begin
            r_cur <= r_rd_next;
        end
        // result register
        if (i_cmd.set_full) begin
            r_status <= hmppk_pkg::ST_FULL;
            r_found  <= '0;
        end else if (i_cmd.set_miss) begin
            r_status <= hmppk_pkg::ST_MISS;
            r_found  <= '0;
        end else if (i_cmd.set_hit) begin
            r_status <= hmppk_pkg::ST_OK;
            r_found  <= (r_op == hmppk_pkg::OP_INSERT) ? 32'd0 : r_rd_val;
        end
    end

    assign o_status_flags.clear_done = r_clr_done;
    assign o_status_flags.is_insert  = (r_op == hmppk_pkg::OP_INSERT);
    assign o_status_flags.pool_full  = (r_used >= NO_ENTRY);
    assign o_status_flags.cur_empty  = (r_cur >= NO_ENTRY);
    assign o_status_flags.match      = (r_rd_addr == r_addr) && (r_rd_tag == r_tag);
    assign o_status      = r_status;
    assign o_found_value = r_found;

endmodule

// File: rtl/core/hmppk_ctrl.sv
module hmppk_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    input  hmppk_pkg::t_status  i_status_flags,
    output hmppk_pkg::t_cmd     o_cmd
);

    hmppk_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hmppk_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            hmppk_pkg::S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status_flags.clear_done) begin
                    o_cmd.clear_step = 1'b0;
                    n_state = hmppk_pkg::S_IDLE;
                end
            end
            hmppk_pkg::S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
                if (i_valid) n_state = hmppk_pkg::S_HASH0;
            end
            hmppk_pkg::S_HASH0: begin
                o_cmd.hash0 = 1'b1;
                n_state = hmppk_pkg::S_HASH1;
            end
            hmppk_pkg::S_HASH1: begin
                o_cmd.hash1 = 1'b1;
                n_state = hmppk_pkg::S_HASH2;
            end
            hmppk_pkg::S_HASH2: begin
                o_cmd.hash2 = 1'b1;
                n_state = hmppk_pkg::S_HEAD;
            end
            hmppk_pkg::S_HEAD: begin
                if (i_status_flags.is_insert && i_status_flags.pool_full) begin
                    o_cmd.set_full = 1'b1;
                    n_state = hmppk_pkg::S_OUT;
                end else begin
                    o_cmd.head_rd = 1'b1;
                    n_state = i_status_flags.is_insert ? hmppk_pkg::S_INSERT
                                                       : hmppk_pkg::S_READ;
                end
            end
            hmppk_pkg::S_INSERT: begin
                o_cmd.insert  = 1'b1;
                o_cmd.set_hit = 1'b1;
                n_state = hmppk_pkg::S_OUT;
            end
            hmppk_pkg::S_READ: begin
                if (i_status_flags.cur_empty) begin
                    o_cmd.set_miss = 1'b1;
                    n_state = hmppk_pkg::S_OUT;
                end else begin
                    o_cmd.entry_rd = 1'b1;
                    n_state = hmppk_pkg::S_CHECK;
                end
            end
            hmppk_pkg::S_CHECK: begin
                if (i_status_flags.match) begin
                    o_cmd.set_hit = 1'b1;
                    n_state = hmppk_pkg::S_OUT;
                end else begin
                    o_cmd.follow = 1'b1;
                    n_state = hmppk_pkg::S_READ;
                end
            end
            hmppk_pkg::S_OUT: begin
                o_valid = 1'b1;
                if (i_ready) n_state = hmppk_pkg::S_IDLE;
            end
            default: n_state = hmppk_pkg::S_IDLE;
        endcase
    end

endmodule

// File: rtl/core/hash_map_pointer_pair_key.sv
// Chained hash map keyed by a 64-bit address and a 32-bit tag, holding 32-bit values.
// Input channel: i_valid/o_ready carries operation (0 lookup, 1 insert), key and value.
// Output channel: o_valid/i_ready carries status (0 ok, 1 miss, 2 full) and found_value.
// Each accepted item gives exactly one result; one item is worked on at a time.
// An item passes through S_HASH0, S_HASH1, S_HASH2 and S_HEAD; an insert then writes its
// entry in S_INSERT, an insert into a full pool goes straight to S_OUT, and a lookup walks
// the chain, S_READ then S_CHECK per entry, through the single read port of the entry memories.
// After the result transfer the block returns to S_IDLE, where it can take the next item.
// The golden-ratio hash uses three 32x32 products, formed in S_HASH0 and S_HASH1, summed in S_HASH2.
// The result register holds until taken; a stalled receiver keeps o_ready low.
// After reset a clearing pass empties every bucket head, with o_ready low. Entries are
// never freed; inserts past POOL_ENTRIES report full.
module hash_map_pointer_pair_key #(
    parameter int HASH_BITS    = 8,
    parameter int POOL_ENTRIES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic [63:0] i_key_address,
    input  logic [31:0] i_key_tag,
    input  logic [31:0] i_new_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_found_value
);

    hmppk_pkg::t_cmd    w_cmd;
    hmppk_pkg::t_status w_flags;

    // sequencer
    hmppk_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .i_status_flags (w_flags),
        .o_cmd          (w_cmd)
    );

    // storage and hashing
    hmppk_datapath #(
        .HASH_BITS    (HASH_BITS),
        .POOL_ENTRIES (POOL_ENTRIES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_operation    (i_operation),
        .i_key_address  (i_key_address),
        .i_key_tag      (i_key_tag),
        .i_new_value    (i_new_value),
        .o_status_flags (w_flags),
        .o_status       (o_status),
        .o_found_value  (o_found_value)
    );

endmodule
